[design/ssc_pkg.sv]
package ssc_pkg;

    localparam int unsigned SW_W    = 8;
    localparam int unsigned KEY_W   = 4;
    localparam int unsigned SEL_W   = 4;
    localparam int unsigned SEG_W   = 8;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned NDIGITS = 4;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [NDIGITS*DIGIT_W-1:0] bcd_count_t;
    typedef logic [SEL_W-1:0] sel_t;
    typedef logic [SEG_W-1:0] seg_t;
    typedef logic [1:0] pos_t;

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    localparam pos_t POS_UNITS     = 2'd0;
    localparam pos_t POS_TENS      = 2'd1;
    localparam pos_t POS_HUNDREDS  = 2'd2;
    localparam pos_t POS_THOUSANDS = 2'd3;

    localparam sel_t SEL_UNITS     = 4'b0111;
    localparam sel_t SEL_TENS      = 4'b1011;
    localparam sel_t SEL_HUNDREDS  = 4'b1101;
    localparam sel_t SEL_THOUSANDS = 4'b1110;
    localparam sel_t SEL_OFF       = 4'b1111;

    localparam seg_t SEG_BLANK = 8'h00;
    localparam seg_t SEG_DP    = 8'h80;

    function automatic seg_t seg_code(input digit_t d);
        seg_t s;
        case (d)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

    // Double dabble: 8-bit binary to three BCD digits
    function automatic logic [11:0] bin_to_bcd(input logic [SW_W-1:0] b);
        logic [11:0] acc;
        acc = '0;
        for (int i = SW_W - 1; i >= 0; i--) begin
            if (acc[3:0] >= 4'd5) acc[3:0] = acc[3:0] + 4'd3;
            if (acc[7:4] >= 4'd5) acc[7:4] = acc[7:4] + 4'd3;
            if (acc[11:8] >= 4'd5) acc[11:8] = acc[11:8] + 4'd3;
            acc = {acc[10:0], b[i]};
        end
        return acc;
    endfunction

endpackage

[design/ssc_in_if.sv]
interface ssc_in_if;
    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic [ssc_pkg::SW_W-1:0]  switch_value;
    logic [ssc_pkg::KEY_W-1:0] key_bits;

    modport source (output valid, req_type, switch_value, key_bits, input ready);
    modport sink   (input valid, req_type, switch_value, key_bits, output ready);
endinterface

[design/ssc_out_if.sv]
interface ssc_out_if;
    logic              valid;
    logic              ready;
    ssc_pkg::sel_t     digit_select;
    ssc_pkg::seg_t     segments;
    logic              busy_res;

    modport source (output valid, digit_select, segments, busy_res, input ready);
    modport sink   (input valid, digit_select, segments, busy_res, output ready);
endinterface

[design/seven_segment_countdown_display.sv]
// An accepted transaction has its result in the output register in the next cycle.
// Throughput: one transaction per cycle; input ready holds while the output register
// is free or being drained in the same cycle.
// The count is kept as four BCD digits, so no division stands in the display path.
// Reset (asynchronous, active low): idle, count zero, all keys enabled, output empty.
module seven_segment_countdown_display #(
    parameter int unsigned FRAMES_PER_STEP = 20,
    parameter int unsigned PAUSE_SLOTS     = 40
) (
    input  logic      clk,
    input  logic      rst_n,
    ssc_in_if.sink    item,
    ssc_out_if.source result
);

    localparam int unsigned SHOW_SLOTS = FRAMES_PER_STEP * 4;
    localparam int unsigned STEP_SLOTS = SHOW_SLOTS + PAUSE_SLOTS;
    localparam int unsigned SLOT_W     = $clog2(STEP_SLOTS + 1);
    localparam logic [SLOT_W-1:0] SHOW_END = SLOT_W'(SHOW_SLOTS);
    localparam logic [SLOT_W-1:0] STEP_END = SLOT_W'(STEP_SLOTS - 1);

    ssc_pkg::bcd_count_t              count_reg, count_next;
    logic [ssc_pkg::KEY_W-1:0]        mask_reg, mask_next;
    logic [SLOT_W-1:0]                slot_reg, slot_next;
    logic                             running_reg, running_next;

    ssc_pkg::sel_t                    sel_reg, sel_next;
    ssc_pkg::seg_t                    seg_reg, seg_next;
    logic                             busy_reg, busy_next;
    logic                             out_valid_reg, out_valid_next;

    logic                             accept;
    ssc_pkg::pos_t                    pos;
    ssc_pkg::digit_t                  digit;
    logic                             key_on;
    ssc_pkg::bcd_count_t              count_dec;
    logic [11:0]                      sw_bcd;
    ssc_pkg::bcd_count_t              count_load;

    assign item.ready = !out_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;
    assign pos        = slot_reg[1:0];

    assign sw_bcd     = ssc_pkg::bin_to_bcd(item.switch_value);
    assign count_load = {sw_bcd, 4'd0};

    always_comb
    begin
        digit  = count_reg[3:0];
        key_on = mask_reg[3];
        unique case (pos)
            ssc_pkg::POS_UNITS:
            begin
                digit  = count_reg[3:0];
                key_on = mask_reg[3];
            end
            ssc_pkg::POS_TENS:
            begin
                digit  = count_reg[7:4];
                key_on = mask_reg[2];
            end
            ssc_pkg::POS_HUNDREDS:
            begin
                digit  = count_reg[11:8];
                key_on = mask_reg[1];
            end
            ssc_pkg::POS_THOUSANDS:
            begin
                digit  = count_reg[15:12];
                key_on = mask_reg[0];
            end
            default:
            begin
                digit  = count_reg[3:0];
                key_on = mask_reg[3];
            end
        endcase
        if (!key_on)
        begin
            digit = '0;
        end
    end

    // Subtract two in BCD, saturating at zero
    always_comb
    begin
        logic borrow;
        count_dec = count_reg;
        borrow    = 1'b0;
        if (count_reg[15:4] == 12'd0 && count_reg[3:0] < 4'd2)
        begin
            count_dec = '0;
        end
        else
        begin
            if (count_reg[3:0] >= 4'd2)
            begin
                count_dec[3:0] = count_reg[3:0] - 4'd2;
            end
            else
            begin
                count_dec[3:0] = count_reg[3:0] + 4'd8;
                borrow         = 1'b1;
            end
            for (int i = 1; i < ssc_pkg::NDIGITS; i++)
            begin
                if (borrow)
                begin
                    if (count_reg[i*4 +: 4] == 4'd0)
                    begin
                        count_dec[i*4 +: 4] = 4'd9;
                    end
                    else
                    begin
                        count_dec[i*4 +: 4] = count_reg[i*4 +: 4] - 4'd1;
                        borrow              = 1'b0;
                    end
                end
            end
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        mask_next      = mask_reg;
        slot_next      = slot_reg;
        running_next   = running_reg;
        sel_next       = sel_reg;
        seg_next       = seg_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg && !result.ready;

        if (accept)
        begin
            out_valid_next = 1'b1;
            sel_next       = ssc_pkg::SEL_OFF;
            seg_next       = ssc_pkg::SEG_BLANK;
            busy_next      = 1'b0;
            if (item.req_type == ssc_pkg::REQ_START)
            begin
                count_next   = count_load;
                mask_next    = item.key_bits;
                slot_next    = '0;
                running_next = (sw_bcd != 12'd0);
                busy_next    = (sw_bcd != 12'd0);
            end
            else if (running_reg)
            begin
                busy_next = 1'b1;
                if (slot_reg < SHOW_END)
                begin
                    unique case (pos)
                        ssc_pkg::POS_UNITS:     sel_next = ssc_pkg::SEL_UNITS;
                        ssc_pkg::POS_TENS:      sel_next = ssc_pkg::SEL_TENS;
                        ssc_pkg::POS_HUNDREDS:  sel_next = ssc_pkg::SEL_HUNDREDS;
                        ssc_pkg::POS_THOUSANDS: sel_next = ssc_pkg::SEL_THOUSANDS;
                        default:                sel_next = ssc_pkg::SEL_OFF;
                    endcase
                    seg_next = ssc_pkg::seg_code(digit);
                    if (pos == ssc_pkg::POS_TENS)
                    begin
                        seg_next = seg_next | ssc_pkg::SEG_DP;
                    end
                end
                if (slot_reg >= STEP_END)
                begin
                    slot_next  = '0;
                    count_next = count_dec;
                    if (count_dec == '0)
                    begin
                        running_next = 1'b0;
                    end
                end
                else
                begin
                    slot_next = slot_reg + SLOT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            mask_reg      <= '1;
            slot_reg      <= '0;
            running_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            mask_reg      <= mask_next;
            slot_reg      <= slot_next;
            running_reg   <= running_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg  <= sel_next;
        seg_reg  <= seg_next;
        busy_reg <= busy_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.digit_select = sel_reg;
    assign result.segments     = seg_reg;
    assign result.busy_res     = busy_reg;

endmodule

[tb/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FRAMES_PER_STEP = 20;
    localparam int unsigned PAUSE_SLOTS     = 40;
    localparam int unsigned SHOW_SLOTS      = FRAMES_PER_STEP * 4;
    localparam int unsigned STEP_SLOTS      = SHOW_SLOTS + PAUSE_SLOTS;
    localparam int unsigned SLOT_W          = $clog2(STEP_SLOTS + 1);
    localparam int unsigned COUNT_W         = 12;
    localparam int unsigned PHASE_ITEMS     = 250;
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned LOG_LIMIT       = 40;

    localparam ssc_pkg::seg_t DIGIT_GLYPH [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    typedef struct packed {
        ssc_pkg::sel_t digit_select;
        ssc_pkg::seg_t segments;
        logic          busy;
    } frame_t;

    logic clk;
    logic rst_n;

    ssc_in_if  item_ch ();
    ssc_out_if result_ch ();

    seven_segment_countdown_display #(
        .FRAMES_PER_STEP (FRAMES_PER_STEP),
        .PAUSE_SLOTS     (PAUSE_SLOTS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    logic [COUNT_W-1:0]        shown_count;
    logic [ssc_pkg::KEY_W-1:0] key_mask;
    logic [SLOT_W-1:0]         slot_idx;
    logic                      running;

    frame_t      frames_due [$];
    int unsigned errors;
    int unsigned items_sent;
    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("[seven_segment_countdown_display] ERROR");
        $finish;
    end

    function automatic ssc_pkg::seg_t digit_glyph(input ssc_pkg::pos_t pos);
        int unsigned place;
        logic [3:0]  value;
        case (pos)
            ssc_pkg::POS_UNITS:    place = 1;
            ssc_pkg::POS_TENS:     place = 10;
            ssc_pkg::POS_HUNDREDS: place = 100;
            default:               place = 1000;
        endcase
        value = 4'((int'(shown_count) / place) % 10);
        if (!key_mask[2'd3 - pos])
            value = 4'd0;
        return DIGIT_GLYPH[value];
    endfunction

    function automatic frame_t predict_frame(input logic req,
                                             input logic [ssc_pkg::SW_W-1:0] sw,
                                             input logic [ssc_pkg::KEY_W-1:0] keys);
        frame_t        f;
        ssc_pkg::pos_t pos;
        f.digit_select = ssc_pkg::SEL_OFF;
        f.segments     = ssc_pkg::SEG_BLANK;
        f.busy         = 1'b0;
        if (req == ssc_pkg::REQ_START)
        begin
            shown_count = COUNT_W'(int'(sw) * 10);
            key_mask    = keys;
            slot_idx    = '0;
            running     = (shown_count != 0);
            f.busy      = running;
        end
        else if (running)
        begin
            f.busy = 1'b1;
            if (slot_idx < SHOW_SLOTS)
            begin
                pos = ssc_pkg::pos_t'(slot_idx[1:0]);
                case (pos)
                    ssc_pkg::POS_UNITS:    f.digit_select = ssc_pkg::SEL_UNITS;
                    ssc_pkg::POS_TENS:     f.digit_select = ssc_pkg::SEL_TENS;
                    ssc_pkg::POS_HUNDREDS: f.digit_select = ssc_pkg::SEL_HUNDREDS;
                    default:               f.digit_select = ssc_pkg::SEL_THOUSANDS;
                endcase
                f.segments = digit_glyph(pos);
                if (pos == ssc_pkg::POS_TENS)
                    f.segments = f.segments | ssc_pkg::SEG_DP;
            end
            if (slot_idx == STEP_SLOTS - 1)
            begin
                slot_idx    = '0;
                shown_count = (shown_count >= 2) ? COUNT_W'(shown_count - 2) : '0;
                if (shown_count == 0)
                    running = 1'b0;
            end
            else
                slot_idx = slot_idx + 1'b1;
        end
        return f;
    endfunction

    task automatic report(input string what);
        errors++;
        if (errors <= LOG_LIMIT)
            $display("%0t mismatch: %s", $time, what);
    endtask

    task automatic check_result();
        frame_t want;
        if (frames_due.size() == 0)
            report("result transaction with nothing expected");
        else
        begin
            want = frames_due.pop_front();
            if (result_ch.digit_select !== want.digit_select)
                report($sformatf("digit_select %b, expected %b",
                                 result_ch.digit_select, want.digit_select));
            if (result_ch.segments !== want.segments)
                report($sformatf("segments %h, expected %h",
                                 result_ch.segments, want.segments));
            if (result_ch.busy_res !== want.busy)
                report($sformatf("busy_res %b, expected %b",
                                 result_ch.busy_res, want.busy));
        end
    endtask

    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
                check_result();
            result_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    task automatic send_item(input logic req, input logic [ssc_pkg::SW_W-1:0] sw,
                             input logic [ssc_pkg::KEY_W-1:0] keys);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.req_type     <= req;
        item_ch.switch_value <= sw;
        item_ch.key_bits     <= keys;
        do
            @(posedge clk);
        while (!item_ch.ready);
        frames_due.push_back(predict_frame(req, sw, keys));
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(ssc_pkg::REQ_TICK,
                  ssc_pkg::SW_W'($urandom_range(0, 255)),
                  ssc_pkg::KEY_W'($urandom_range(0, 15)));
    endtask

    task automatic test_idle_after_reset();
        send_item(ssc_pkg::REQ_TICK, 8'hFF, 4'hF);
        send_item(ssc_pkg::REQ_TICK, 8'h00, 4'h0);
    endtask

    task automatic test_zero_load();
        send_item(ssc_pkg::REQ_START, 8'h00, 4'hF);
        send_item(ssc_pkg::REQ_TICK, 8'hFF, 4'hF);
    endtask

    task automatic test_digit_frames();
        send_item(ssc_pkg::REQ_START, 8'hFF, 4'hF);
        repeat (8) send_tick();
    endtask

    task automatic test_key_masking();
        send_item(ssc_pkg::REQ_START, 8'd123, 4'b0101);
        repeat (4) send_tick();
        // restart over a running countdown
        send_item(ssc_pkg::REQ_START, 8'd99, 4'b1010);
        repeat (4) send_tick();
    endtask

    task automatic test_countdown_end();
        // run the shortest countdown through its last step and a few idle ticks
        send_item(ssc_pkg::REQ_START, 8'd1, 4'hF);
        repeat (STEP_SLOTS * 5 + 3) send_tick();
    endtask

    task automatic test_random_traffic(input int unsigned idle_pct,
                                       input int unsigned stall_pct);
        int unsigned first;
        int unsigned ticks;
        int unsigned pick;
        logic [ssc_pkg::SW_W-1:0] sw;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        first = items_sent;
        while (items_sent - first < PHASE_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
            begin
                sw    = 8'd1;
                ticks = $urandom_range(STEP_SLOTS * 5 - 3, STEP_SLOTS * 5 + 3);
            end
            else if (pick == 4)
            begin
                sw    = 8'd0;
                ticks = $urandom_range(1, 4);
            end
            else if (pick < 8)
            begin
                sw    = ssc_pkg::SW_W'($urandom_range(1, 255));
                ticks = $urandom_range(1, STEP_SLOTS + 20);
            end
            else
            begin
                sw    = ssc_pkg::SW_W'($urandom_range(0, 255));
                ticks = $urandom_range(0, 10);
            end
            send_item(ssc_pkg::REQ_START, sw, ssc_pkg::KEY_W'($urandom_range(0, 15)));
            while (ticks != 0 && items_sent - first < PHASE_ITEMS)
            begin
                send_tick();
                ticks--;
            end
        end
    endtask

    initial
    begin
        errors             = 0;
        items_sent         = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        shown_count        = '0;
        key_mask           = '1;
        slot_idx           = '0;
        running            = 1'b0;
        rst_n              = 1'b0;
        item_ch.valid        = 1'b0;
        item_ch.req_type     = ssc_pkg::REQ_TICK;
        item_ch.switch_value = '0;
        item_ch.key_bits     = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_after_reset();
        test_zero_load();
        test_digit_frames();
        test_key_masking();
        test_countdown_end();
        test_random_traffic(0, 0);
        test_random_traffic(66, 0);
        test_random_traffic(0, 66);
        test_random_traffic(34, 34);

        item_ch.valid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("[seven_segment_countdown_display] OK");
        else
            $display("[seven_segment_countdown_display] ERROR");
        $finish;
    end

endmodule
